@@ sv/three_wire_rtc_serial_master_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the three-wire serial master
// Shared check templates, clocked on clk with reset rst_n.
// ---------------------------------------------------------------------------
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_DEFINES_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define TWR_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger
`define TWR_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

@@ sv/tw_rtc_pkg.sv @@
// ---------------------------------------------------------------------------
// tw_rtc_pkg
// Types and constants shared by the three-wire serial master modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tw_rtc_pkg;

    // Operation codes on the input tuser field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SETUP = 2'd0;
    localparam logic [1:0] CFG_PHASE = 2'd1;
    localparam logic [1:0] CFG_HOLD  = 2'd2;

    localparam logic [7:0] SETUP_RESET = 8'd4;
    localparam logic [7:0] PHASE_RESET = 8'd1;
    localparam logic [7:0] HOLD_RESET  = 8'd1;

    // Bit counts: one byte, command plus data byte
    localparam logic [4:0] BITS_BYTE = 5'd8;
    localparam logic [4:0] BITS_PAIR = 5'd16;

    // Queue occupancy limit
    localparam logic [1:0] QUEUE_FULL = 2'd2;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_WRITE,
        KIND_READ
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] command;
        logic [7:0] write_data;
        logic       io_in;
    } item_t;

    // Packed so that ce lands in bit 0
    typedef struct packed {
        logic       refused;
        logic [7:0] read_result;
        logic       done_res;
        logic       busy_res;
        logic       io_drive;
        logic       io_out;
        logic       sclk;
        logic       ce;
    } result_t;

endpackage

@@ sv/tw_rtc_front.sv @@
// ---------------------------------------------------------------------------
// tw_rtc_front
// Input stage: accepts items, classifies the operation, registers the item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tw_rtc_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [7:0]         command,
    input  logic [7:0]         write_data,
    input  logic               io_in,
    output tw_rtc_pkg::item_t  item,
    output logic               item_valid,
    input  logic               item_ready
);
    import tw_rtc_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    kind_t kind;

    // Unused op code counts as a tick
    always_comb
    begin
        unique case (op)
            OP_WRITE: kind = KIND_WRITE;
            OP_READ:  kind = KIND_READ;
            default:  kind = KIND_TICK;
        endcase
    end

    assign in_ready = !valid_reg || item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{kind: kind, command: command, write_data: write_data, io_in: io_in};
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

@@ sv/tw_rtc_queue.sv @@
// ---------------------------------------------------------------------------
// tw_rtc_queue
// Two-entry item queue between the input stage and the sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_wire_rtc_serial_master_defines.svh"

module tw_rtc_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  tw_rtc_pkg::item_t  push_item,
    input  logic               push_valid,
    output logic               push_ready,
    output tw_rtc_pkg::item_t  pop_item,
    output logic               pop_valid,
    input  logic               pop_ready
);
    import tw_rtc_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    item_t      head_reg;
    item_t      tail_reg;
    logic       push;
    logic       pop;

    assign push_ready = count_reg != QUEUE_FULL;
    assign pop_valid  = count_reg != 2'd0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = head_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Head always holds the oldest item; tail the second one
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == QUEUE_FULL)
            begin
                head_reg <= tail_reg;
            end
            else if (push)
            begin
                head_reg <= push_item;
            end
        end
        else if (push && count_reg == 2'd0)
        begin
            head_reg <= push_item;
        end

        if (push && ((count_reg == 2'd1 && !pop) || (count_reg == QUEUE_FULL && pop)))
        begin
            tail_reg <= push_item;
        end
    end

    `TWR_ASSERT_ALWAYS(a_count_bound, count_reg != 2'd3, "queue count beyond two entries")
    `TWR_ASSERT_NEXT(a_push_grows, push && !pop, count_reg != 2'd0, "push left queue empty")
    `TWR_ASSERT_NEXT(a_full_holds, count_reg == QUEUE_FULL && !pop, count_reg == QUEUE_FULL,
                     "full queue lost an item without a pop")

endmodule

@@ sv/tw_rtc_back.sv @@
// ---------------------------------------------------------------------------
// tw_rtc_back
// Pin sequencer: steps the serial transaction once per item, holds the
// timing registers and registers one result per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_wire_rtc_serial_master_defines.svh"

module tw_rtc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tw_rtc_pkg::item_t    item,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tw_rtc_pkg::result_t  result
);
    import tw_rtc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP,
        PH_WR_LOW,
        PH_WR_HIGH,
        PH_RD_HIGH,
        PH_RD_LOW,
        PH_HOLD
    } phase_t;

    logic [7:0] setup_ticks_reg;
    logic [7:0] phase_ticks_reg;
    logic [7:0] hold_ticks_reg;

    phase_t     phase_reg,      phase_next;
    logic [4:0] bit_count_reg,  bit_count_next;
    logic [7:0] wait_count_reg, wait_count_next;
    logic [15:0] shift_out_reg, shift_out_next;
    logic [7:0] shift_in_reg,   shift_in_next;
    logic       is_read_reg,    is_read_next;
    logic       out_valid_reg;
    result_t    result_reg,     result_next;

    logic       start;
    logic       refused;
    logic       done;
    logic       pop;
    logic [4:0] bit_inc;
    logic       drive;

    assign pop        = item_valid && (!out_valid_reg || out_ready);
    assign item_ready = !out_valid_reg || out_ready;
    assign start      = item.kind == KIND_WRITE || item.kind == KIND_READ;
    assign bit_inc    = bit_count_reg + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_ticks_reg <= SETUP_RESET;
            phase_ticks_reg <= PHASE_RESET;
            hold_ticks_reg  <= HOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            priority case (cfg_index)
                CFG_SETUP: setup_ticks_reg <= cfg_data;
                CFG_PHASE: phase_ticks_reg <= cfg_data;
                CFG_HOLD:  hold_ticks_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        wait_count_next = wait_count_reg;
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        is_read_next    = is_read_reg;
        refused         = 1'b0;
        done            = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (start)
            begin
                is_read_next    = item.kind == KIND_READ;
                shift_out_next  = {item.write_data, item.command};
                shift_in_next   = 8'd0;
                bit_count_next  = 5'd0;
                wait_count_next = setup_ticks_reg;
                phase_next      = PH_SETUP;
            end
        end
        else
        begin
            refused = start;
            // A count of zero or one both end the phase on this item
            if (wait_count_reg > 8'd1)
            begin
                wait_count_next = wait_count_reg - 8'd1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SETUP:
                    begin
                        bit_count_next  = 5'd0;
                        phase_next      = PH_WR_LOW;
                        wait_count_next = phase_ticks_reg;
                    end
                    PH_WR_LOW:
                    begin
                        phase_next      = PH_WR_HIGH;
                        wait_count_next = phase_ticks_reg;
                    end
                    PH_WR_HIGH:
                    begin
                        bit_count_next = bit_inc;
                        shift_out_next = {1'b0, shift_out_reg[15:1]};
                        if (bit_inc >= (is_read_reg ? BITS_BYTE : BITS_PAIR))
                        begin
                            if (is_read_reg)
                            begin
                                // Turn the line around and take bit zero now
                                bit_count_next   = 5'd0;
                                phase_next       = PH_RD_HIGH;
                                shift_in_next[0] = shift_in_reg[0] | item.io_in;
                                wait_count_next  = phase_ticks_reg;
                            end
                            else
                            begin
                                phase_next      = PH_HOLD;
                                wait_count_next = hold_ticks_reg;
                            end
                        end
                        else
                        begin
                            phase_next      = PH_WR_LOW;
                            wait_count_next = phase_ticks_reg;
                        end
                    end
                    PH_RD_HIGH:
                    begin
                        phase_next      = PH_RD_LOW;
                        wait_count_next = phase_ticks_reg;
                    end
                    PH_RD_LOW:
                    begin
                        bit_count_next = bit_inc;
                        if (bit_inc >= BITS_BYTE)
                        begin
                            phase_next      = PH_HOLD;
                            wait_count_next = hold_ticks_reg;
                        end
                        else
                        begin
                            phase_next                  = PH_RD_HIGH;
                            shift_in_next[bit_inc[2:0]] = shift_in_reg[bit_inc[2:0]]
                                                        | item.io_in;
                            wait_count_next             = phase_ticks_reg;
                        end
                    end
                    default:
                    begin
                        phase_next      = PH_IDLE;
                        wait_count_next = 8'd0;
                        done            = 1'b1;
                    end
                endcase
            end
        end

        drive = phase_next == PH_WR_LOW || phase_next == PH_WR_HIGH;
        result_next.ce          = phase_next != PH_IDLE && phase_next != PH_HOLD;
        result_next.sclk        = phase_next == PH_WR_HIGH || phase_next == PH_RD_HIGH;
        result_next.io_drive    = drive;
        result_next.io_out      = drive & shift_out_next[0];
        result_next.busy_res    = phase_next != PH_IDLE;
        result_next.done_res    = done;
        result_next.read_result = shift_in_next;
        result_next.refused     = refused;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 5'd0;
            wait_count_reg <= 8'd0;
            shift_out_reg  <= 16'd0;
            shift_in_reg   <= 8'd0;
            is_read_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                wait_count_reg <= wait_count_next;
                shift_out_reg  <= shift_out_next;
                shift_in_reg   <= shift_in_next;
                is_read_reg    <= is_read_next;
                result_reg     <= result_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    `TWR_ASSERT_ALWAYS(a_done_idle, !(out_valid_reg && result_reg.done_res && result_reg.busy_res),
                       "done reported while still busy")
    `TWR_ASSERT_ALWAYS(a_pins_framed,
                       !(out_valid_reg && (result_reg.sclk || result_reg.io_drive) && !result_reg.ce),
                       "clock or data driven with chip enable low")
    `TWR_ASSERT_ALWAYS(a_out_driven, !(result_reg.io_out && !result_reg.io_drive),
                       "data level shown on a released line")
    `TWR_ASSERT_NEXT(a_idle_tick, pop && phase_reg == PH_IDLE && !start,
                     !result_reg.ce && !result_reg.busy_res && !result_reg.done_res
                     && !result_reg.refused,
                     "tick while idle changed the pins or flags")

endmodule

@@ sv/three_wire_rtc_serial_master.sv @@
// ---------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Three-wire LSB-first serial master for a clock chip, stream interface.
// ---------------------------------------------------------------------------
// Input items arrive on the s_axis channel: tuser carries the operation
// (tick, start write, start read), tdata the command byte, the write byte
// and the sampled data line. Every input item yields exactly one result on
// the m_axis channel with the pin levels and flags after that item's step.
// The user must write the timing registers via cfg_wr_en / cfg_index / cfg_data
// only while no item is in flight; the block itself does not enforce this. Index 3 is ignored.
// An accepted item passes through the input register, which loads it at the
// accepting edge, then the two-entry queue and then the sequencer's output
// register before its result is valid. Throughput is one item per cycle while
// the result receiver does not stall, bounded by the single sequencer step per
// clock.
// When the result receiver stalls, the output register holds its item and
// the queue and input register fill up, after which s_axis_tready drops.
// Reset returns the sequencer to idle, the pins to idle levels and the
// timing registers to setup 4, phase 1, hold 1.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_wire_rtc_serial_master
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // command[7:0], write_data[15:8], io_in[16], zero
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // ce, sclk, io_out, io_drive, busy_res, done_res,
                                        // read_result[13:6], refused[14], zero
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import tw_rtc_pkg::*;

    item_t   front_item;
    logic    front_valid;
    logic    front_ready;
    item_t   queue_item;
    logic    queue_valid;
    logic    queue_ready;
    result_t result;

    tw_rtc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .op         (s_axis_tuser),
        .command    (s_axis_tdata[7:0]),
        .write_data (s_axis_tdata[15:8]),
        .io_in      (s_axis_tdata[16]),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    tw_rtc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (queue_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    tw_rtc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (queue_item),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result     (result)
    );

    assign m_axis_tdata = {1'b0, result};

endmodule
